// ----- design/pcls_pkg.sv -----
// pcls_pkg: shared widths, codes and reset values of the plane side classifier
// used by the channel interfaces, the classifier top level and its checker
`default_nettype none

package pcls_pkg;

    // field widths
    localparam int unsigned TYPE_W   = 2;
    localparam int unsigned COORD_W  = 32;
    localparam int unsigned NORM_W   = 16;
    localparam int unsigned OFF_W    = 32;
    localparam int unsigned TOL_W    = 31;
    localparam int unsigned RAD_W    = 31;
    localparam int unsigned SIDE_W   = 2;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // fixed-point alignment: Q2.14 * Q16.16 gives Q.30, offsets move up by 14
    localparam int unsigned FRAC_SHIFT = 14;
    localparam int unsigned PROD_W     = NORM_W + COORD_W;
    localparam int unsigned DIST_W     = PROD_W + 3;
    localparam int unsigned NUM_AXES   = 3;

    // request kinds; any code with the high bit set is a sphere
    localparam logic [TYPE_W-1:0] REQ_POINT = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_BOX   = 2'd1;

    // result codes
    typedef enum logic [SIDE_W-1:0] {
        SIDE_IN    = 2'd0,
        SIDE_FRONT = 2'd1,
        SIDE_BACK  = 2'd2,
        SIDE_CROSS = 2'd3
    } side_t;

    // register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NORMAL_X  = 3'd0,
        CFG_NORMAL_Y  = 3'd1,
        CFG_NORMAL_Z  = 3'd2,
        CFG_OFFSET    = 3'd3,
        CFG_TOLERANCE = 3'd4
    } cfg_index_t;

    // register reset values
    localparam logic signed [NORM_W-1:0] NORMAL_X_RST  = 16'sd0;
    localparam logic signed [NORM_W-1:0] NORMAL_Y_RST  = 16'sd0;
    localparam logic signed [NORM_W-1:0] NORMAL_Z_RST  = 16'sd16384;
    localparam logic signed [OFF_W-1:0]  OFFSET_RST    = 32'sd0;
    localparam logic [TOL_W-1:0]         TOLERANCE_RST = 31'd1;

endpackage

`default_nettype wire

// ----- design/pcls_if.sv -----
// pcls_if: valid/ready channel interfaces for classifier requests and results
// depends on pcls_pkg for field widths
`default_nettype none

interface pcls_req_if;
    logic                                     valid;
    logic                                     ready;
    logic [pcls_pkg::TYPE_W-1:0]              req_type;
    logic signed [pcls_pkg::COORD_W-1:0]      pos_x;
    logic signed [pcls_pkg::COORD_W-1:0]      pos_y;
    logic signed [pcls_pkg::COORD_W-1:0]      pos_z;
    logic signed [pcls_pkg::COORD_W-1:0]      hi_x;
    logic signed [pcls_pkg::COORD_W-1:0]      hi_y;
    logic signed [pcls_pkg::COORD_W-1:0]      hi_z;
    logic [pcls_pkg::RAD_W-1:0]               radius;

    modport source (
        output valid, req_type, pos_x, pos_y, pos_z, hi_x, hi_y, hi_z, radius,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_x, pos_y, pos_z, hi_x, hi_y, hi_z, radius,
        output ready
    );
endinterface

interface pcls_res_if;
    logic                         valid;
    logic                         ready;
    logic [pcls_pkg::SIDE_W-1:0]  side;

    modport source (output valid, side, input ready);
    modport sink   (input valid, side, output ready);
endinterface

`default_nettype wire

// ----- design/plane_side_classifier_top.sv -----
// plane_side_classifier_top: point, box and sphere classification against one plane
// depends on pcls_pkg and the pcls_req_if / pcls_res_if channel interfaces
//
//  channel | dir | handshake        | beat contents
//  --------+-----+------------------+-----------------------------------------
//  req     | in  | valid / ready    | req_type, pos_x/y/z, hi_x/y/z, radius
//  res     | out | valid / ready    | side
//  cfg     | in  | cfg_we only      | cfg_index, cfg_data
//
// one beat per cycle sustained while res.ready is high; an accepted beat loads the product
// stage, then moves into the result register once that register is empty or being taken
// reset clears the pipeline valid bits and loads the plane registers
// a stalled result holds its stage; the product stage still takes one more beat,
// so req.ready only drops while both stages hold data and res.ready is low
`default_nettype none

module plane_side_classifier_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    pcls_req_if.sink                             req,
    pcls_res_if.source                           res,
    input  wire logic                            cfg_we,
    input  wire logic [pcls_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pcls_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned PW = pcls_pkg::PROD_W;
    localparam int unsigned DW = pcls_pkg::DIST_W;
    localparam int unsigned FS = pcls_pkg::FRAC_SHIFT;

    // plane registers
    logic signed [pcls_pkg::NORM_W-1:0] normal_reg [pcls_pkg::NUM_AXES];
    logic signed [pcls_pkg::OFF_W-1:0]  offset_reg;
    logic [pcls_pkg::TOL_W-1:0]         tol_reg;

    // product stage
    logic                               s1_valid_reg;
    logic [pcls_pkg::TYPE_W-1:0]        s1_type_reg;
    logic signed [PW-1:0]               s1_pp_reg [pcls_pkg::NUM_AXES];
    logic signed [PW-1:0]               s1_ph_reg [pcls_pkg::NUM_AXES];
    logic [pcls_pkg::RAD_W-1:0]         s1_rad_reg;

    // result stage
    logic                               out_valid_reg;
    pcls_pkg::side_t                    side_reg;
    pcls_pkg::side_t                    side_next;

    logic                               advance;
    logic                               s1_load;
    logic signed [pcls_pkg::COORD_W-1:0] pos_in [pcls_pkg::NUM_AXES];
    logic signed [pcls_pkg::COORD_W-1:0] hi_in  [pcls_pkg::NUM_AXES];
    logic                               n_pos  [pcls_pkg::NUM_AXES];

    logic signed [DW-1:0] off_q;
    logic signed [DW-1:0] tol_q;
    logic signed [DW-1:0] rad_q;
    logic signed [DW-1:0] pt_dist;
    logic signed [DW-1:0] box_min;
    logic signed [DW-1:0] box_max;

    // handshake: the result register drains when empty or taken downstream
    assign advance   = !out_valid_reg || res.ready;
    assign req.ready = advance || !s1_valid_reg;
    assign s1_load   = req.valid && req.ready;

    assign res.valid = out_valid_reg;
    assign res.side  = side_reg;

    assign pos_in[0] = req.pos_x;
    assign pos_in[1] = req.pos_y;
    assign pos_in[2] = req.pos_z;
    assign hi_in[0]  = req.hi_x;
    assign hi_in[1]  = req.hi_y;
    assign hi_in[2]  = req.hi_z;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg[0] <= pcls_pkg::NORMAL_X_RST;
            normal_reg[1] <= pcls_pkg::NORMAL_Y_RST;
            normal_reg[2] <= pcls_pkg::NORMAL_Z_RST;
            offset_reg    <= pcls_pkg::OFFSET_RST;
            tol_reg       <= pcls_pkg::TOLERANCE_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pcls_pkg::CFG_NORMAL_X:  normal_reg[0] <= cfg_data[pcls_pkg::NORM_W-1:0];
                pcls_pkg::CFG_NORMAL_Y:  normal_reg[1] <= cfg_data[pcls_pkg::NORM_W-1:0];
                pcls_pkg::CFG_NORMAL_Z:  normal_reg[2] <= cfg_data[pcls_pkg::NORM_W-1:0];
                pcls_pkg::CFG_OFFSET:    offset_reg    <= cfg_data[pcls_pkg::OFF_W-1:0];
                pcls_pkg::CFG_TOLERANCE: tol_reg       <= cfg_data[pcls_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // product stage valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // per-axis products of the normal with both box corners
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_type_reg <= req.req_type;
            s1_rad_reg  <= req.radius;
            for (int a = 0; a < pcls_pkg::NUM_AXES; a++)
            begin
                s1_pp_reg[a] <= PW'(normal_reg[a]) * PW'(pos_in[a]);
                s1_ph_reg[a] <= PW'(normal_reg[a]) * PW'(hi_in[a]);
            end
        end
    end

    // offsets and thresholds aligned to Q.30
    assign off_q = {{(DW-pcls_pkg::OFF_W-FS){offset_reg[pcls_pkg::OFF_W-1]}},
                    offset_reg, {FS{1'b0}}};
    assign tol_q = {{(DW-pcls_pkg::TOL_W-FS){1'b0}}, tol_reg, {FS{1'b0}}};
    assign rad_q = {{(DW-pcls_pkg::RAD_W-FS){1'b0}}, s1_rad_reg, {FS{1'b0}}};

    // normal sign picks which corner gives the low extreme; zero counts as negative
    always_comb
    begin
        for (int a = 0; a < pcls_pkg::NUM_AXES; a++)
            n_pos[a] = !normal_reg[a][pcls_pkg::NORM_W-1] && (normal_reg[a] != '0);
    end

    // distance sums
    always_comb
    begin
        pt_dist = off_q;
        box_min = off_q;
        box_max = off_q;
        for (int a = 0; a < pcls_pkg::NUM_AXES; a++)
        begin
            pt_dist = pt_dist + DW'(s1_pp_reg[a]);
            box_min = box_min + (n_pos[a] ? DW'(s1_pp_reg[a]) : DW'(s1_ph_reg[a]));
            box_max = box_max + (n_pos[a] ? DW'(s1_ph_reg[a]) : DW'(s1_pp_reg[a]));
        end
    end

    // classification
    always_comb
    begin
        case (s1_type_reg)
            pcls_pkg::REQ_POINT:
            begin
                if ((pt_dist < tol_q) && (pt_dist > -tol_q))
                    side_next = pcls_pkg::SIDE_IN;
                else if (pt_dist > tol_q)
                    side_next = pcls_pkg::SIDE_FRONT;
                else
                    side_next = pcls_pkg::SIDE_BACK;
            end
            pcls_pkg::REQ_BOX:
            begin
                if (box_min > 0)
                    side_next = pcls_pkg::SIDE_FRONT;
                else if (box_max < 0)
                    side_next = pcls_pkg::SIDE_BACK;
                else
                    side_next = pcls_pkg::SIDE_CROSS;
            end
            default:
            begin
                if (pt_dist > rad_q)
                    side_next = pcls_pkg::SIDE_FRONT;
                else if (pt_dist < -rad_q)
                    side_next = pcls_pkg::SIDE_BACK;
                else
                    side_next = pcls_pkg::SIDE_CROSS;
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
            side_reg <= side_next;
    end

endmodule

`default_nettype wire

// ----- design/pcls_checker.sv -----
// pcls_checker: port-level checks on the plane side classifier
// depends on pcls_pkg; bound to plane_side_classifier_top below
`default_nettype none

module pcls_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         req_valid,
    input wire logic                         req_ready,
    input wire logic                         res_valid,
    input wire logic                         res_ready,
    input wire logic [pcls_pkg::SIDE_W-1:0]  res_side
);

    // a held result keeps its value
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_side))
        else $error("result changed while stalled");

    // a new result traces back to a request beat through the product stage and the result register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result without matching request");

    // empty output side never back-pressures requests
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> req_ready)
        else $error("request stalled with empty output");

    // with both stages full, request ready follows result ready
    a_full_ready: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && res_valid && !res_ready |=> req_ready == res_ready)
        else $error("request ready wrong with pipeline full");

endmodule

bind plane_side_classifier_top pcls_checker u_pcls_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_side  (res.side)
);

`default_nettype wire

// ----- dv/tb_plane_side_classifier_top.sv -----
// tb_plane_side_classifier_top: self-checking bench for the plane side classifier
// streams point, box and sphere beats under several plane settings and stall patterns
// depends on pcls_pkg, the pcls_req_if / pcls_res_if channels and plane_side_classifier_top
`default_nettype none

module tb_plane_side_classifier_top;
    import pcls_pkg::*;

    localparam int unsigned HALF_PERIOD   = 5;
    localparam int unsigned RESET_CYCLES  = 5;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned STALL_LIMIT   = 2000;

    // sphere codes; the block decodes the high bit, so both mean sphere
    localparam logic [TYPE_W-1:0] REQ_SPHERE     = 2'd2;
    localparam logic [TYPE_W-1:0] REQ_SPHERE_ALT = 2'd3;

    // one request beat as the bench keeps it
    typedef struct packed {
        logic [TYPE_W-1:0]  kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [COORD_W-1:0] hi_x;
        logic [COORD_W-1:0] hi_y;
        logic [COORD_W-1:0] hi_z;
        logic [RAD_W-1:0]   radius;
    } shape_beat_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    pcls_req_if req_ch ();
    pcls_res_if res_ch ();

    plane_side_classifier_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // plane copy used for prediction
    longint plane_normal [NUM_AXES];
    longint plane_offset;
    longint plane_tolerance;

    shape_beat_t shapes_to_send [$];
    side_t       sides_due [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_asked    = 0;
    int unsigned holds_granted  = 0;
    int unsigned hold_left      = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned mismatches     = 0;
    logic        req_taken      = 1'b0;

    always #HALF_PERIOD clk = ~clk;

    // expected side of one beat against the current plane, all in Q.30
    function automatic side_t plane_side_of(shape_beat_t b);
        longint lo [NUM_AXES];
        longint hi [NUM_AXES];
        longint dist_q30;
        longint min_sum;
        longint max_sum;
        longint off_q30;
        longint tol_q30;
        longint rad_q30;
        longint mag;
        side_t  s;
        lo[0] = longint'($signed(b.pos_x));
        lo[1] = longint'($signed(b.pos_y));
        lo[2] = longint'($signed(b.pos_z));
        hi[0] = longint'($signed(b.hi_x));
        hi[1] = longint'($signed(b.hi_y));
        hi[2] = longint'($signed(b.hi_z));
        off_q30 = plane_offset * (longint'(1) << FRAC_SHIFT);
        tol_q30 = plane_tolerance * (longint'(1) << FRAC_SHIFT);
        rad_q30 = longint'(b.radius) * (longint'(1) << FRAC_SHIFT);
        dist_q30 = off_q30;
        min_sum  = 0;
        max_sum  = 0;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            dist_q30 += plane_normal[i] * lo[i];
            // corner selection follows the normal sign, zero takes the swapped pick
            if (plane_normal[i] > 0)
            begin
                min_sum += plane_normal[i] * lo[i];
                max_sum += plane_normal[i] * hi[i];
            end
            else
            begin
                min_sum += plane_normal[i] * hi[i];
                max_sum += plane_normal[i] * lo[i];
            end
        end
        if (b.kind == REQ_POINT)
        begin
            mag = (dist_q30 < 0) ? -dist_q30 : dist_q30;
            if (mag < tol_q30)
                s = SIDE_IN;
            else if (dist_q30 > tol_q30)
                s = SIDE_FRONT;
            else
                s = SIDE_BACK;
        end
        else if (b.kind == REQ_BOX)
        begin
            if (min_sum + off_q30 > 0)
                s = SIDE_FRONT;
            else if (max_sum + off_q30 < 0)
                s = SIDE_BACK;
            else
                s = SIDE_CROSS;
        end
        else
        begin
            if (dist_q30 > rad_q30)
                s = SIDE_FRONT;
            else if (dist_q30 < -rad_q30)
                s = SIDE_BACK;
            else
                s = SIDE_CROSS;
        end
        return s;
    endfunction

    function automatic shape_beat_t directed_shape(logic [TYPE_W-1:0] kind,
            logic [COORD_W-1:0] px, logic [COORD_W-1:0] py, logic [COORD_W-1:0] pz,
            logic [COORD_W-1:0] hx, logic [COORD_W-1:0] hy, logic [COORD_W-1:0] hz,
            logic [31:0] r);
        shape_beat_t b;
        b.kind   = kind;
        b.pos_x  = px;
        b.pos_y  = py;
        b.pos_z  = pz;
        b.hi_x   = hx;
        b.hi_y   = hy;
        b.hi_z   = hz;
        b.radius = r[RAD_W-1:0];
        return b;
    endfunction

    // full range, a few units around the origin, or a few raw lsbs
    function automatic logic [COORD_W-1:0] random_coord(int unsigned scale);
        logic [COORD_W-1:0] v;
        case (scale)
            0:       v = $urandom;
            1:       v = $urandom_range(0, 32'd2097152) - 32'd1048576;
            default: v = $urandom_range(0, 64) - 32'd32;
        endcase
        return v;
    endfunction

    function automatic shape_beat_t random_shape();
        shape_beat_t b;
        int unsigned scale;
        int unsigned pick;
        scale = $urandom_range(2);
        pick  = $urandom_range(11);
        if (pick < 4)
            b.kind = REQ_POINT;
        else if (pick < 8)
            b.kind = REQ_BOX;
        else if (pick < 11)
            b.kind = REQ_SPHERE;
        else
            b.kind = REQ_SPHERE_ALT;
        b.pos_x = random_coord(scale);
        b.pos_y = random_coord(scale);
        b.pos_z = random_coord(scale);
        b.hi_x  = random_coord(scale);
        b.hi_y  = random_coord(scale);
        b.hi_z  = random_coord(scale);
        // mostly well-ordered boxes, some left inverted
        if (b.kind == REQ_BOX && $urandom_range(7) != 0)
        begin
            if ($signed(b.pos_x) > $signed(b.hi_x))
                {b.pos_x, b.hi_x} = {b.hi_x, b.pos_x};
            if ($signed(b.pos_y) > $signed(b.hi_y))
                {b.pos_y, b.hi_y} = {b.hi_y, b.pos_y};
            if ($signed(b.pos_z) > $signed(b.hi_z))
                {b.pos_z, b.hi_z} = {b.hi_z, b.pos_z};
        end
        case (scale)
            0:       b.radius = RAD_W'($urandom);
            1:       b.radius = RAD_W'($urandom_range(0, 32'd4194304));
            default: b.radius = RAD_W'($urandom_range(0, 256));
        endcase
        return b;
    endfunction

    // register write, mirrored into the prediction plane
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            CFG_NORMAL_X:  plane_normal[0] = longint'($signed(data[NORM_W-1:0]));
            CFG_NORMAL_Y:  plane_normal[1] = longint'($signed(data[NORM_W-1:0]));
            CFG_NORMAL_Z:  plane_normal[2] = longint'($signed(data[NORM_W-1:0]));
            CFG_OFFSET:    plane_offset    = longint'($signed(data[OFF_W-1:0]));
            CFG_TOLERANCE: plane_tolerance = longint'(data[TOL_W-1:0]);
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // queue a batch under one idle pattern and wait until the block is empty
    task automatic play_batch(int unsigned idle_pct, int unsigned stall_pct,
                              int unsigned count, bit long_hold);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            shapes_to_send.push_back(random_shape());
        if (long_hold)
            holds_asked++;
        do
            @(negedge clk);
        while (shapes_to_send.size() != 0 || req_ch.valid || sides_due.size() != 0);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    // request driver: a beat is held until taken, then the next may follow a gap
    always @(negedge clk)
    begin : sender
        shape_beat_t b;
        if (!rst_n)
            req_ch.valid <= 1'b0;
        else if (!req_ch.valid || req_taken)
        begin
            if (shapes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                b = shapes_to_send.pop_front();
                req_ch.req_type <= b.kind;
                req_ch.pos_x    <= b.pos_x;
                req_ch.pos_y    <= b.pos_y;
                req_ch.pos_z    <= b.pos_z;
                req_ch.hi_x     <= b.hi_x;
                req_ch.hi_y     <= b.hi_y;
                req_ch.hi_z     <= b.hi_z;
                req_ch.radius   <= b.radius;
                req_ch.valid    <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // result ready: random stalls plus long hold-offs on request
    always @(negedge clk)
    begin : receiver
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            res_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end
        else if (holds_granted != holds_asked)
        begin
            res_ch.ready  <= 1'b0;
            hold_left     <= LONG_HOLD;
            holds_granted <= holds_granted + 1;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // predict on every request beat, check every result beat in order
    always @(posedge clk)
    begin : monitor
        shape_beat_t seen;
        side_t       want;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                seen.kind   = req_ch.req_type;
                seen.pos_x  = req_ch.pos_x;
                seen.pos_y  = req_ch.pos_y;
                seen.pos_z  = req_ch.pos_z;
                seen.hi_x   = req_ch.hi_x;
                seen.hi_y   = req_ch.hi_y;
                seen.hi_z   = req_ch.hi_z;
                seen.radius = req_ch.radius;
                sides_due.push_back(plane_side_of(seen));
            end
            if (res_ch.valid && res_ch.ready)
            begin
                if (sides_due.size() == 0)
                begin
                    $display("%0t: side %b arrived with nothing expected", $time, res_ch.side);
                    mismatches++;
                end
                else
                begin
                    want = sides_due.pop_front();
                    if (res_ch.side !== want)
                    begin
                        $display("%0t: side expected %s (%b), actual %b",
                                 $time, want.name(), want, res_ch.side);
                        mismatches++;
                    end
                end
            end
        end
        req_taken <= rst_n && req_ch.valid && req_ch.ready;
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge clk)
    begin : watchdog
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = CFG_NORMAL_X;
        cfg_data        = '0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_POINT;
        req_ch.pos_x    = '0;
        req_ch.pos_y    = '0;
        req_ch.pos_z    = '0;
        req_ch.hi_x     = '0;
        req_ch.hi_y     = '0;
        req_ch.hi_z     = '0;
        req_ch.radius   = '0;
        res_ch.ready    = 1'b0;
        plane_normal[0] = longint'(NORMAL_X_RST);
        plane_normal[1] = longint'(NORMAL_Y_RST);
        plane_normal[2] = longint'(NORMAL_Z_RST);
        plane_offset    = longint'(OFFSET_RST);
        plane_tolerance = longint'(TOLERANCE_RST);
        repeat (RESET_CYCLES)
            @(negedge clk);
        rst_n <= 1'b1;

        // reset plane z = 0, tolerance of one lsb
        // points: in plane, distance at the tolerance, just past it, extremes
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 0, 0, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 0, 1, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 0, 2, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 0, -1, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 32'h7FFF_FFFF, 32'h8000_0000,
                                                0, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, -1, -1, -1, -1, -1, -1, -1));
        // boxes: straddling, above, below, inverted, flat, full range
        shapes_to_send.push_back(directed_shape(REQ_BOX, 0, 0, -1, 0, 0, 1, 0));
        shapes_to_send.push_back(directed_shape(REQ_BOX, 0, 0, 1, 0, 0, 5, 0));
        shapes_to_send.push_back(directed_shape(REQ_BOX, 0, 0, -5, 0, 0, -1, 0));
        shapes_to_send.push_back(directed_shape(REQ_BOX, 0, 0, 5, 0, 0, -5, 0));
        shapes_to_send.push_back(directed_shape(REQ_BOX, 0, 0, 0, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_BOX, 32'h8000_0000, 32'h8000_0000,
                                                32'h8000_0000, 32'h7FFF_FFFF,
                                                32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        // spheres: touching, clear in front, clear behind, largest radius
        shapes_to_send.push_back(directed_shape(REQ_SPHERE, 0, 0, 10, 0, 0, 0, 10));
        shapes_to_send.push_back(directed_shape(REQ_SPHERE, 0, 0, 11, 0, 0, 0, 10));
        shapes_to_send.push_back(directed_shape(REQ_SPHERE, 0, 0, -11, 0, 0, 0, 10));
        shapes_to_send.push_back(directed_shape(REQ_SPHERE, 0, 0, -10, 0, 0, 0, 10));
        shapes_to_send.push_back(directed_shape(REQ_SPHERE, 0, 0, 32'h7FFF_FFFF,
                                                0, 0, 0, 32'h7FFF_FFFF));
        // type three goes the sphere path
        shapes_to_send.push_back(directed_shape(REQ_SPHERE_ALT, 0, 0, 11, 0, 0, 0, 10));
        shapes_to_send.push_back(directed_shape(REQ_SPHERE_ALT, 0, 0, 0, 0, 0, 0, 0));
        play_batch(0, 0, 50, 1'b1);

        // plane x = 0 with zero tolerance: a point is never in plane
        write_reg(CFG_NORMAL_X, 32'h0000_4000);
        write_reg(CFG_NORMAL_Y, 32'h0000_0000);
        write_reg(CFG_NORMAL_Z, 32'h0000_0000);
        write_reg(CFG_OFFSET, 32'h0000_0000);
        write_reg(CFG_TOLERANCE, 32'h0000_0000);
        shapes_to_send.push_back(directed_shape(REQ_POINT, 0, 5, 5, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, 1, 0, 0, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_POINT, -1, 0, 0, 0, 0, 0, 0));
        shapes_to_send.push_back(directed_shape(REQ_BOX, 1, 32'h8000_0000, 32'h8000_0000,
                                                2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0));
        play_batch(54, 0, 60, 1'b0);

        // normals beyond unit length, largest offset and tolerance (bit 31 dropped)
        write_reg(CFG_NORMAL_X, 32'hFFFF_8000);
        write_reg(CFG_NORMAL_Y, 32'h0000_7FFF);
        write_reg(CFG_NORMAL_Z, 32'h0000_4000);
        write_reg(CFG_OFFSET, 32'h7FFF_FFFF);
        write_reg(CFG_TOLERANCE, 32'hFFFF_FFFF);
        play_batch(0, 54, 60, 1'b0);

        // mixed unit normals, most negative offset, tolerance of one lsb
        write_reg(CFG_NORMAL_X, 32'h0000_4000);
        write_reg(CFG_NORMAL_Y, 32'hFFFF_C000);
        write_reg(CFG_NORMAL_Z, 32'h0000_C000);
        write_reg(CFG_OFFSET, 32'h8000_0000);
        write_reg(CFG_TOLERANCE, 32'h0000_0001);
        play_batch(31, 31, 60, 1'b1);

        // random planes, cycling through the idle patterns
        for (int k = 0; k < 4; k++)
        begin
            write_reg(CFG_NORMAL_X, $urandom_range(0, 32768) - 32'd16384);
            write_reg(CFG_NORMAL_Y, $urandom_range(0, 32768) - 32'd16384);
            write_reg(CFG_NORMAL_Z, $urandom_range(0, 32768) - 32'd16384);
            if (k % 2 == 0)
                write_reg(CFG_OFFSET, $urandom_range(0, 32'd2097152) - 32'd1048576);
            else
                write_reg(CFG_OFFSET, $urandom);
            write_reg(CFG_TOLERANCE, {1'($urandom), 31'($urandom_range(0, 32'd16777216))});
            case (k)
                0:       play_batch(0, 0, 55, 1'b0);
                1:       play_batch(54, 0, 55, 1'b0);
                2:       play_batch(0, 54, 55, 1'b0);
                default: play_batch(31, 31, 55, 1'b0);
            endcase
        end

        if (mismatches == 0 && sides_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
